### src/stq_pkg.sv
`default_nettype none

package stq_pkg;

    // field widths
    localparam int TIME_W = 40;
    localparam int DUR_W  = 32;
    localparam int TAG_W  = 32;
    localparam int KIND_W = 2;

    // most expiries reported for one tick
    localparam int MAX_RESULTS = 16;
    localparam int POP_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } slot_t;

endpackage

`default_nettype wire

### src/sorted_timeout_queue.sv
`default_nettype none
// sorted timeout queue: one word in, then its result words, one input word at a time
// add: a full queue rejects the word at once; otherwise entries with later deadlines move up
//   one slot each until the scan reaches the head or stops on an earlier entry; tick: the
//   head entries are examined in turn, each due one giving a result word, until the
//   queue empties, 16 pops are reached or an entry is not yet due
// output stalls hold the sequencer; reset clears time, fill count, ring head and both handshakes

module sorted_timeout_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,

    // input channel
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire                          operation,
    input  wire  [stq_pkg::DUR_W-1:0]    duration,
    input  wire  [stq_pkg::TAG_W-1:0]    tag,

    // result channel
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [stq_pkg::KIND_W-1:0]   kind,
    output logic [stq_pkg::TAG_W-1:0]    expired_tag,
    output logic                         last
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TW    = stq_pkg::TIME_W;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD_RD   = 3'd1;
    localparam logic [2:0] S_ADD_CMP  = 3'd2;
    localparam logic [2:0] S_TICK_RD  = 3'd3;
    localparam logic [2:0] S_TICK_CMP = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    // logical position -> physical slot in the ring, head + off wraps at most once
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] s;
        s = {1'b0, head} + {1'b0, off};
        if (s >= (IDX_W+1)'(QUEUE_DEPTH))
            s = s - (IDX_W+1)'(QUEUE_DEPTH);
        return s[IDX_W-1:0];
    endfunction

    // slot memory, ring ordered by deadline starting at head
    stq_pkg::slot_t slot_mem [QUEUE_DEPTH];
    stq_pkg::slot_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    stq_pkg::slot_t   wr_data;
    logic             wr_en;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [2:0]       ret_reg, ret_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TW-1:0]    now_reg, now_next;
    logic [stq_pkg::POP_W-1:0] pop_reg, pop_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;

    // working payload
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [TW-1:0]               dl_reg, dl_next;
    logic [stq_pkg::TAG_W-1:0]   new_tag_reg, new_tag_next;
    logic [stq_pkg::TAG_W-1:0]   pend_tag_reg, pend_tag_next;
    logic [stq_pkg::KIND_W-1:0]  res_kind_reg, res_kind_next;
    logic [stq_pkg::TAG_W-1:0]   res_tag_reg, res_tag_next;
    logic                        res_last_reg, res_last_next;
    logic [stq_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [stq_pkg::TAG_W-1:0]   expired_tag_reg, expired_tag_next;
    logic                        last_reg, last_next;

    logic           in_take;
    logic           out_free;
    logic [TW:0]    dl_sum;
    logic [TW-1:0]  dl_sat;
    logic [IDX_W-1:0] idx_dec;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign expired_tag = expired_tag_reg;
    assign last        = last_reg;

    // deadline = now + duration, saturating at the top of the time range
    assign dl_sum  = {1'b0, now_reg} + {(TW + 1 - stq_pkg::DUR_W)'(0), duration};
    assign dl_sat  = dl_sum[TW] ? stq_pkg::TIME_MAX : dl_sum[TW-1:0];
    assign idx_dec = idx_reg - IDX_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        now_next         = now_reg;
        pop_next         = pop_reg;
        pend_next        = pend_reg;
        idx_next         = idx_reg;
        dl_next          = dl_reg;
        new_tag_next     = new_tag_reg;
        pend_tag_next    = pend_tag_reg;
        res_kind_next    = res_kind_reg;
        res_tag_next     = res_tag_reg;
        res_last_next    = res_last_reg;
        kind_next        = kind_reg;
        expired_tag_next = expired_tag_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg && out_stall;
        rd_addr          = head_reg;
        wr_addr          = phys(head_reg, idx_reg);
        wr_data          = rd_data_reg;
        wr_en            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take) begin
                    if (operation == stq_pkg::OP_ADD) begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                            res_kind_next = stq_pkg::KIND_FULL;
                            res_tag_next  = '0;
                            res_last_next = 1'b1;
                            ret_next      = S_IDLE;
                            state_next    = S_EMIT;
                        end else begin
                            dl_next      = dl_sat;
                            new_tag_next = tag;
                            idx_next     = count_reg[IDX_W-1:0];
                            state_next   = S_ADD_RD;
                        end
                    end else begin
                        if (now_reg != stq_pkg::TIME_MAX)
                            now_next = now_reg + TW'(1);
                        pop_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_TICK_RD;
                    end
                end
            end

            // walk from the tail toward the head, moving later deadlines up one slot
            S_ADD_RD:
            begin
                rd_addr = phys(head_reg, idx_dec);
                if (idx_reg == '0) begin
                    wr_en         = 1'b1;
                    wr_data       = '{deadline: dl_reg, tag: new_tag_reg};
                    count_next    = count_reg + CNT_W'(1);
                    res_kind_next = stq_pkg::KIND_ACCEPT;
                    res_tag_next  = '0;
                    res_last_next = 1'b1;
                    ret_next      = S_IDLE;
                    state_next    = S_EMIT;
                end else begin
                    state_next = S_ADD_CMP;
                end
            end

            S_ADD_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data_reg.deadline > dl_reg) begin
                    wr_data    = rd_data_reg;
                    idx_next   = idx_dec;
                    state_next = S_ADD_RD;
                end else begin
                    // equal deadlines stay ahead of the new entry
                    wr_data       = '{deadline: dl_reg, tag: new_tag_reg};
                    count_next    = count_reg + CNT_W'(1);
                    res_kind_next = stq_pkg::KIND_ACCEPT;
                    res_tag_next  = '0;
                    res_last_next = 1'b1;
                    ret_next      = S_IDLE;
                    state_next    = S_EMIT;
                end
            end

            // head entry is read, next cycle decides whether it is due
            S_TICK_RD:
            begin
                rd_addr = head_reg;
                if (count_reg != '0 && pop_reg < stq_pkg::POP_W'(stq_pkg::MAX_RESULTS)) begin
                    state_next = S_TICK_CMP;
                end else if (pend_reg) begin
                    res_kind_next = stq_pkg::KIND_EXPIRED;
                    res_tag_next  = pend_tag_reg;
                    res_last_next = 1'b1;
                    ret_next      = S_IDLE;
                    state_next    = S_EMIT;
                end else begin
                    state_next = S_IDLE;
                end
            end

            // one expiry is held back so the final one can carry last
            S_TICK_CMP:
            begin
                if (rd_data_reg.deadline <= now_reg) begin
                    head_next     = phys(head_reg, IDX_W'(1));
                    count_next    = count_reg - CNT_W'(1);
                    pop_next      = pop_reg + stq_pkg::POP_W'(1);
                    pend_tag_next = rd_data_reg.tag;
                    pend_next     = 1'b1;
                    if (pend_reg) begin
                        res_kind_next = stq_pkg::KIND_EXPIRED;
                        res_tag_next  = pend_tag_reg;
                        res_last_next = 1'b0;
                        ret_next      = S_TICK_RD;
                        state_next    = S_EMIT;
                    end else begin
                        state_next = S_TICK_RD;
                    end
                end else if (pend_reg) begin
                    res_kind_next = stq_pkg::KIND_EXPIRED;
                    res_tag_next  = pend_tag_reg;
                    res_last_next = 1'b1;
                    ret_next      = S_IDLE;
                    state_next    = S_EMIT;
                end else begin
                    state_next = S_IDLE;
                end
            end

            // hand the result word to the output register once it has room
            S_EMIT:
            begin
                if (out_free) begin
                    out_valid_next   = 1'b1;
                    kind_next        = res_kind_reg;
                    expired_tag_next = res_tag_reg;
                    last_next        = res_last_reg;
                    state_next       = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            now_reg       <= '0;
            pop_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            now_reg       <= now_next;
            pop_reg       <= pop_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        dl_reg          <= dl_next;
        new_tag_reg     <= new_tag_next;
        pend_tag_reg    <= pend_tag_next;
        res_kind_reg    <= res_kind_next;
        res_tag_reg     <= res_tag_next;
        res_last_reg    <= res_last_next;
        kind_reg        <= kind_next;
        expired_tag_reg <= expired_tag_next;
        last_reg        <= last_next;
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_data;
        rd_data_reg <= slot_mem[rd_addr];
    end

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;

    localparam int QDEPTH       = 16;
    localparam int RANDOM_WORDS = 400;
    localparam int CALM_FROM    = 340;    // no idling on either side from here on
    localparam int HOLD_AT      = 150;    // long receiver hold-off starts near this word
    localparam int LONG_HOLD    = 500;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    // one result word as the block sends it
    typedef struct packed {
        logic [stq_pkg::KIND_W-1:0] kind;
        logic [stq_pkg::TAG_W-1:0]  tag;
        logic                       last;
    } result_t;

    // one row of the directed table; typed rows carry their single result inline
    typedef struct packed {
        logic                       op;
        logic [stq_pkg::DUR_W-1:0]  dur;
        logic [stq_pkg::TAG_W-1:0]  tg;
        logic                       typed;
        logic [stq_pkg::KIND_W-1:0] want_kind;
    } dir_row_t;

    logic                         clk;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         operation   = stq_pkg::OP_ADD;
    logic [stq_pkg::DUR_W-1:0]    duration    = '0;
    logic [stq_pkg::TAG_W-1:0]    tag         = '0;
    logic                         out_stall   = 1'b0;
    logic                         in_stall;
    logic                         out_valid;
    logic [stq_pkg::KIND_W-1:0]   kind;
    logic [stq_pkg::TAG_W-1:0]    expired_tag;
    logic                         last;

    // timer model state
    logic [stq_pkg::TIME_W-1:0]   timer_now;
    logic [stq_pkg::TIME_W-1:0]   slot_deadline [QDEPTH];
    logic [stq_pkg::TAG_W-1:0]    slot_tag      [QDEPTH];
    int                           slot_fill;

    // result words still owed by the block, oldest first
    result_t             owed_results[$];

    int                  error_count   = 0;
    int                  cycle_count   = 0;
    int                  words_sent    = 0;
    bit                  calm          = 1'b0;
    bit                  long_hold_req = 1'b0;
    bit                  long_hold_done = 1'b0;
    int                  hold_left     = 0;
    int                  stall_left    = 0;

    // directed table: quiet tick, extremes of duration and tag, equal deadlines,
    // fill to the top, a rejected add, then one tick that drains fifteen entries
    dir_row_t directed_rows [23] = '{
        '{stq_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0, stq_pkg::KIND_EXPIRED},
        '{stq_pkg::OP_ADD,  32'h0000_0000, 32'h0000_0000, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0001, 32'hA5A5_A5A5, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0001, 32'h5A5A_5A5A, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, stq_pkg::KIND_EXPIRED},
        '{stq_pkg::OP_ADD,  32'h0000_0001, 32'h0000_0101, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0000, 32'h0000_0102, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0001, 32'h0000_0103, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0000, 32'h0000_0104, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0001, 32'h0000_0105, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0001, 32'h0000_0106, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0000, 32'h0000_0107, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0000, 32'h0000_0108, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0001, 32'h0000_0109, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0000, 32'h0000_010A, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0001, 32'h0000_010B, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0000, 32'h0000_010C, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0001, 32'h0000_010D, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0000, 32'h0000_010E, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0001, 32'h0000_010F, 1'b1, stq_pkg::KIND_ACCEPT},
        '{stq_pkg::OP_ADD,  32'h0000_0005, 32'hDEAD_BEEF, 1'b1, stq_pkg::KIND_FULL},
        '{stq_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0, stq_pkg::KIND_EXPIRED}
    };
    // rows above: empty-queue tick with no word, far-off deadline, same deadline in
    // fifo order, a tick that pops three, sixteen stored, a rejected add, fifteen expire

    sorted_timeout_queue #(
        .QUEUE_DEPTH (QDEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .duration    (duration),
        .tag         (tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .expired_tag (expired_tag),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic result_t make_result(input logic [stq_pkg::KIND_W-1:0] k,
                                            input logic [stq_pkg::TAG_W-1:0] t,
                                            input logic l);
        result_t r;
        r.kind = k;
        r.tag  = t;
        r.last = l;
        return r;
    endfunction

    // timer model: applies one word and returns the result words it causes
    task automatic predict_timer(input logic op, input logic [stq_pkg::DUR_W-1:0] dur,
                                 input logic [stq_pkg::TAG_W-1:0] tg,
                                 output result_t res[$]);
        logic [stq_pkg::TIME_W:0] due;
        int                       pos;
        int                       n;
        res = {};
        if (op == stq_pkg::OP_ADD)
        begin
            if (slot_fill >= QDEPTH)
            begin
                res.push_back(make_result(stq_pkg::KIND_FULL, '0, 1'b1));
            end
            else
            begin
                // deadline clamps at the top of the time range
                due = {1'b0, timer_now}
                      + {(stq_pkg::TIME_W + 1 - stq_pkg::DUR_W)'(0), dur};
                if (due > {1'b0, stq_pkg::TIME_MAX})
                    due = {1'b0, stq_pkg::TIME_MAX};
                // insert after every entry not later, so equal deadlines stay fifo
                pos = 0;
                while (pos < slot_fill && slot_deadline[pos] <= due[stq_pkg::TIME_W-1:0])
                    pos++;
                for (int i = slot_fill; i > pos; i--)
                begin
                    slot_deadline[i] = slot_deadline[i-1];
                    slot_tag[i]      = slot_tag[i-1];
                end
                slot_deadline[pos] = due[stq_pkg::TIME_W-1:0];
                slot_tag[pos]      = tg;
                slot_fill++;
                res.push_back(make_result(stq_pkg::KIND_ACCEPT, '0, 1'b1));
            end
        end
        else
        begin
            // time sticks at its maximum
            if (timer_now != stq_pkg::TIME_MAX)
                timer_now++;
            n = 0;
            while (n < slot_fill && n < stq_pkg::MAX_RESULTS && slot_deadline[n] <= timer_now)
            begin
                res.push_back(make_result(stq_pkg::KIND_EXPIRED, slot_tag[n], 1'b0));
                n++;
            end
            if (n > 0)
            begin
                res[n-1].last = 1'b1;
                for (int i = n; i < slot_fill; i++)
                begin
                    slot_deadline[i-n] = slot_deadline[i];
                    slot_tag[i-n]      = slot_tag[i];
                end
                slot_fill -= n;
            end
        end
    endtask

    // offers one word, waits for it to be taken, then books its results
    task automatic send_word(input logic op, input logic [stq_pkg::DUR_W-1:0] dur,
                             input logic [stq_pkg::TAG_W-1:0] tg, input logic typed,
                             input logic [stq_pkg::KIND_W-1:0] typed_kind);
        result_t predicted[$];
        int      gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        duration  <= dur;
        tag       <= tg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_timer(op, dur, tg, predicted);
        // typed rows take their result straight from the table
        if (typed)
            owed_results.push_back(make_result(typed_kind, '0, 1'b1));
        else
            foreach (predicted[i])
                owed_results.push_back(predicted[i]);
        words_sent++;
        if (words_sent == HOLD_AT)
            long_hold_req = 1'b1;
    endtask

    task automatic check_result();
        result_t want;
        if (owed_results.size() == 0)
        begin
            $error("unexpected result word: kind %0d expired_tag %h last %0d",
                   kind, expired_tag, last);
            error_count++;
        end
        else
        begin
            want = owed_results.pop_front();
            if (kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                error_count++;
            end
            if (expired_tag !== want.tag)
            begin
                $error("expired_tag: expected %h, got %h", want.tag, expired_tag);
                error_count++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, last);
                error_count++;
            end
        end
    endtask

    // receiver: checks each taken word, then picks the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result();
        if (long_hold_req && !long_hold_done)
        begin
            // long hold-off so the block backs up and stalls its input
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 7) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        int                        burst;
        int                        big_left;
        logic [stq_pkg::DUR_W-1:0] dur;

        timer_now = '0;
        slot_fill = 0;
        big_left  = 2;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].dur, directed_rows[i].tg,
                      directed_rows[i].typed, directed_rows[i].want_kind);

        // random part: bursts of adds with short timeouts, mixed at random with bursts of ticks
        // that carry junk in the unused fields; at most two far-off timeouts park for good
        while (words_sent < RANDOM_WORDS + $size(directed_rows))
        begin
            if (words_sent >= CALM_FROM)
                calm = 1'b1;
            if ($urandom_range(0, 1) == 0)
            begin
                burst = $urandom_range(1, 10);
                repeat (burst)
                begin
                    if (big_left > 0 && $urandom_range(0, 99) == 0)
                    begin
                        dur = $urandom;
                        big_left--;
                    end
                    else if ($urandom_range(0, 7) == 0)
                        dur = $urandom_range(0, 60);
                    else
                        dur = $urandom_range(0, 12);
                    send_word(stq_pkg::OP_ADD, dur, $urandom, 1'b0, stq_pkg::KIND_ACCEPT);
                end
            end
            else
            begin
                burst = $urandom_range(1, 8);
                repeat (burst)
                    send_word(stq_pkg::OP_TICK, $urandom, $urandom, 1'b0,
                              stq_pkg::KIND_EXPIRED);
            end
        end
        in_valid <= 1'b0;

        while (owed_results.size() != 0)
            @(posedge clk);
        // a quiet tick may still be scanning; any stray word shows up here
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire

### sorted_timeout_queue.f
src/stq_pkg.sv
src/sorted_timeout_queue.sv
test/tb.sv
